>>> hdl/max_priority_queue_assert.svh
// Assertion macros used by the priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpq check failed");

// Next-cycle implication, checked outside reset.
`define MPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpq check failed");

`endif

>>> hdl/mpq_pkg.sv
// Package with widths, codes and transaction types of the priority queue.
`timescale 1ns / 1ps
package mpq_pkg;

  localparam int QUEUE_DEPTH   = 32;
  localparam int ID_BITS       = 20;
  localparam int PRIORITY_BITS = 16;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Priority sits in the upper bits, so a plain unsigned compare gives pair order.
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [ID_BITS-1:0]       id;
  } pair_t;

  typedef struct packed {
    op_t                      func;
    logic [ID_BITS-1:0]       item_id;
    logic [PRIORITY_BITS-1:0] item_priority;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [ID_BITS-1:0]    popped_id;
    logic [COUNT_BITS-1:0] entry_count;
  } out_t;

  // Chain-wide command for one update cycle.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_cmd_t;

endpackage

>>> hdl/mpq_cell.sv
// One cell of the sorted chain: holds a pair and trades with its neighbors.
`timescale 1ns / 1ps
module mpq_cell (
  input  logic              clk,
  input  mpq_pkg::cell_cmd_t cmd,
  input  mpq_pkg::pair_t    new_pair,
  input  logic              occ,
  input  mpq_pkg::pair_t    left_pair,
  input  logic              left_above,
  input  mpq_pkg::pair_t    right_pair,
  output mpq_pkg::pair_t    pair,
  output logic              above
);
  import mpq_pkg::*;

  pair_t pair_r;
  pair_t pair_nxt;

  // The new pair belongs above this cell when the cell is empty or ranks lower.
  assign above = !occ || (new_pair > pair_r);
  assign pair  = pair_r;

  // Insert shifts the lower part of the chain down by one; pop shifts the whole chain up.
  always_comb begin
    pair_nxt = pair_r;
    if (cmd.ins_en) begin
      if (above) begin
        pair_nxt = left_above ? left_pair : new_pair;
      end
    end else if (cmd.pop_en) begin
      pair_nxt = right_pair;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

endmodule

>>> hdl/max_priority_queue.sv
// Max-priority queue built as a sorted shift chain of cells.
// A command passes the command register, then the chain update, in which every cell
// moves in parallel; the result strobe then comes from the output register. The block
// takes no new command until the chain update of the last one is done, at any depth.
// Reset empties the queue and drops the strobe; cell contents are not cleared.
// Results cannot be stalled; busy alone paces the input.
`timescale 1ns / 1ps
module max_priority_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mpq_pkg::in_t   in_item,
  output logic           out_valid,
  output mpq_pkg::out_t  out_item
);
  import mpq_pkg::*;

  // Command register.
  logic                  cmd_valid_r;
  op_t                   cmd_op_r;
  pair_t                 cmd_pair_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  out_valid_r;
  out_t                  out_r;
  out_t                  out_nxt;
  cell_cmd_t             cell_cmd;
  logic                  is_full;
  logic                  is_empty;

  pair_t                 cell_pair  [QUEUE_DEPTH];
  logic                  cell_above [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;

  assign busy      = cmd_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= start && !cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !cmd_valid_r) begin
      cmd_op_r        <= in_item.func;
      cmd_pair_r.prio <= in_item.item_priority;
      cmd_pair_r.id   <= in_item.item_id;
    end
  end

  // Occupancy thermometer: cell i holds a pair when i is below the count.
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_occ
      assign occ[gi] = (count_r > COUNT_BITS'(gi));
    end
  endgenerate

  assign is_full  = (count_r == COUNT_BITS'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // Chain command: a full insert or an empty pop leaves the chain alone.
  always_comb begin
    cell_cmd.ins_en = cmd_valid_r && (cmd_op_r == OP_INSERT) && !is_full;
    cell_cmd.pop_en = cmd_valid_r && (cmd_op_r == OP_POP) && !is_empty;
  end

  // The cell chain, highest pair at cell zero.
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      pair_t left_pair;
      logic  left_above;
      pair_t right_pair;
      if (gi == 0) begin : g_head
        assign left_pair  = cmd_pair_r;
        assign left_above = 1'b0;
      end else begin : g_mid
        assign left_pair  = cell_pair[gi-1];
        assign left_above = cell_above[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_pair = cell_pair[gi];
      end else begin : g_body
        assign right_pair = cell_pair[gi+1];
      end
      mpq_cell u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .new_pair   (cmd_pair_r),
        .occ        (occ[gi]),
        .left_pair  (left_pair),
        .left_above (left_above),
        .right_pair (right_pair),
        .pair       (cell_pair[gi]),
        .above      (cell_above[gi])
      );
    end
  endgenerate

  // Result and count for the transaction in the update cycle.
  always_comb begin
    count_nxt         = count_r;
    out_nxt.status    = ST_INSERTED;
    out_nxt.popped_id = '0;
    case (cmd_op_r)
      OP_INSERT: begin
        if (is_full) begin
          out_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.status    = ST_POPPED;
          out_nxt.popped_id = cell_pair[0].id;
          count_nxt         = count_r - COUNT_BITS'(1);
        end
      end
      default: begin
        out_nxt.status = ST_INSERTED;
      end
    endcase
    out_nxt.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_valid_r;
      if (cmd_valid_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid_r) begin
      out_r <= out_nxt;
    end
  end

  // Checks on the sequencing and the count.
`include "max_priority_queue_assert.svh"

  `MPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= COUNT_BITS'(QUEUE_DEPTH))
  `MPQ_ASSERT_NEXT(a_cmd_strobe, clk, rst_n, cmd_valid_r, out_valid_r && !cmd_valid_r)
  `MPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `MPQ_ASSERT_NOW(a_count_report, clk, rst_n, out_valid_r, out_r.entry_count == count_r)

endmodule

>>> tb/mpq_tracker_pkg.sv
// Scoreboard class that predicts and checks the responses of the priority queue.
`timescale 1ns / 1ps
package mpq_tracker_pkg;

  import mpq_pkg::*;

  class mpq_tracker;
    // Shadow copy of the held pairs, in arrival order.
    pair_t       held[$];
    // Responses predicted for accepted commands and not yet seen.
    out_t        pending[$];
    int unsigned failures;

    // Count a failure and print the first few of them.
    function void report(string what, out_t exp, out_t got);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s: expected status=%0d id=%h count=%0d, got status=%0d id=%h count=%0d",
                 $realtime, what, exp.status, exp.popped_id, exp.entry_count,
                 got.status, got.popped_id, got.entry_count);
      end
    endfunction

    // Apply one accepted command to the shadow queue and queue its response.
    function void record_command(in_t cmd);
      out_t exp;
      int   best;
      exp.status    = ST_INSERTED;
      exp.popped_id = '0;
      if (cmd.func == OP_INSERT) begin
        if (held.size() >= QUEUE_DEPTH) begin
          exp.status = ST_FULL;
        end else begin
          held.push_back('{prio: cmd.item_priority, id: cmd.item_id});
        end
      end else if (held.size() == 0) begin
        exp.status = ST_EMPTY;
      end else begin
        // The highest priority wins; equal priorities go to the larger identifier.
        best = 0;
        for (int i = 1; i < held.size(); i++) begin
          if ({held[i].prio, held[i].id} > {held[best].prio, held[best].id}) begin
            best = i;
          end
        end
        exp.status    = ST_POPPED;
        exp.popped_id = held[best].id;
        held.delete(best);
      end
      exp.entry_count = COUNT_BITS'(held.size());
      pending.push_back(exp);
    endfunction

    // Compare one response strobe with the oldest prediction.
    function void check_response(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        exp = '0;
        report("Unexpected response", exp, got);
      end else begin
        exp = pending.pop_front();
        if (got.status !== exp.status || got.popped_id !== exp.popped_id ||
            got.entry_count !== exp.entry_count) begin
          report("Mismatch", exp, got);
        end
      end
    endfunction

    // Predictions that never got a response are failures.
    function void check_drained();
      if (pending.size() != 0) begin
        failures++;
        $display("[%0t] %0d responses never arrived", $realtime, pending.size());
      end
    endfunction
  endclass

endpackage

>>> tb/tb_max_priority_queue.sv
// Self-checking testbench for the max-priority queue.
`timescale 1ns / 1ps
module tb_max_priority_queue;

  import mpq_pkg::*;
  import mpq_tracker_pkg::*;

  localparam int unsigned TOTAL_COMMANDS = 1350;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  mpq_tracker  tracker;
  int unsigned cycle_count = 0;

  max_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Record accepted transactions and check response strobes on each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        tracker.record_command(in_item);
      end
      if (out_valid === 1'b1) begin
        tracker.check_response(out_item);
      end
    end
  end

  function automatic in_t make_cmd(op_t op, logic [ID_BITS-1:0] id,
                                   logic [PRIORITY_BITS-1:0] prio);
    in_t cmd;
    cmd.func          = op;
    cmd.item_id       = id;
    cmd.item_priority = prio;
    return cmd;
  endfunction

  // Random command; priorities and identifiers often come from narrow sets so ties occur.
  function automatic in_t random_command(int unsigned insert_pct);
    op_t                      op;
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
    case ($urandom_range(0, 3))
      0: prio = PRIORITY_BITS'($urandom_range(0, 3));
      1: prio = $urandom_range(0, 1) ? '1 : '0;
      default: prio = PRIORITY_BITS'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: id = ID_BITS'($urandom_range(0, 7));
      1: id = '1 - ID_BITS'($urandom_range(0, 3));
      default: id = ID_BITS'($urandom);
    endcase
    return make_cmd(op, id, prio);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit no_gaps);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one command and hold it until the block takes it.
  task automatic send_command(input in_t cmd);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Idle the input for a number of cycles with junk on the payload.
  task automatic idle_input(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= make_cmd(op_t'(1'($urandom)), ID_BITS'($urandom),
                          PRIORITY_BITS'($urandom));
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted response has come back.
  task automatic wait_for_responses();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned insert_pct;
    bit          no_gaps;

    tracker = new;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: pop on an empty queue, field extremes, ties and duplicate pairs.
    send_command(make_cmd(OP_POP, '1, '1));
    send_command(make_cmd(OP_INSERT, '0, '0));
    send_command(make_cmd(OP_INSERT, '1, '1));
    send_command(make_cmd(OP_INSERT, '0, '1));
    send_command(make_cmd(OP_INSERT, '1, '1));
    send_command(make_cmd(OP_INSERT, '1, '0));
    send_command(make_cmd(OP_INSERT, 20'h80000, 16'h8000));
    repeat (6) send_command(make_cmd(OP_POP, '1, '1));
    send_command(make_cmd(OP_POP, '0, '0));
    send_command(make_cmd(OP_INSERT, 20'h55555, 16'h0002));
    send_command(make_cmd(OP_INSERT, 20'haaaaa, 16'h0002));
    send_command(make_cmd(OP_POP, '0, '0));
    send_command(make_cmd(OP_INSERT, 20'h00001, 16'h0003));
    send_command(make_cmd(OP_POP, '0, '0));
    send_command(make_cmd(OP_POP, '0, '0));
    send_command(make_cmd(OP_POP, '0, '0));
    wait_for_responses();

    // Random phases: first fill past full, then drain past empty, then mixed mixes.
    sent  = 0;
    phase = 0;
    while (sent < TOTAL_COMMANDS) begin
      case (phase)
        0: begin
          insert_pct = 95;
          phase_len  = 50;
        end
        1: begin
          insert_pct = 5;
          phase_len  = 50;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: insert_pct = 10;
            1: insert_pct = 30;
            2: insert_pct = 50;
            3: insert_pct = 70;
            default: insert_pct = 90;
          endcase
          phase_len = $urandom_range(20, 80);
        end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && sent < TOTAL_COMMANDS; i++) begin
        idle_input(pick_gap(no_gaps));
        send_command(random_command(insert_pct));
        sent++;
      end
      if (phase == 1 || $urandom_range(0, 2) == 0) begin
        wait_for_responses();
      end
      phase++;
    end

    // Let the last responses arrive, then watch for stray strobes.
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.check_drained();
    if (tracker.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
